/* design/vtdi_pkg.sv */
// Shared types and constants for the vertex triple dedup indexer.
`timescale 1ns / 1ps
`default_nettype none
package vtdi_pkg;

   // Key store geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 48;
   localparam int REF_W       = 16;
   localparam int ZREF_W      = 17;
   localparam int VTX_W       = 10;

   // Action codes
   localparam logic ACT_INDEX = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // latch the request beat, rewind the scan
      logic rd_en;    // read the key store at the scan index
      logic step;     // advance the scan index
      logic set_hit;  // record a match at the scan index
      logic emit;     // build the response beat, append on a miss
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_act;  // request beat asks for a table clear
      logic empty;      // no entries stored
      logic match;      // read key equals the latched key
      logic last;       // scan index is the last stored entry
      logic slot_free;  // response register can take a beat
   } dp_status_type;

endpackage
`default_nettype wire

/* design/vtdi_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module vtdi_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/vtdi_ctrl.sv */
// Controller state machine: accept, scan the key store, respond.
`timescale 1ns / 1ps
`default_nettype none
module vtdi_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire vtdi_pkg::dp_status_type st,
   output vtdi_pkg::dp_cmd_type        cmd
);
   import vtdi_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (st.clear_act) begin
                  state_in = ST_IDLE;
               end else if (st.empty) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (st.match) begin
               cmd.set_hit = 1'b1;
               state_in    = ST_RESP;
            end else if (st.last) begin
               state_in = ST_RESP;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_RESP: begin
            if (st.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* design/vtdi_dpath.sv */
// Datapath: key store, entry count, scan index, compare and response register.
`timescale 1ns / 1ps
`default_nettype none
module vtdi_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vtdi_pkg::dp_cmd_type          cmd,
   output vtdi_pkg::dp_status_type            st,
   input  wire logic                          req_action,
   input  wire logic [vtdi_pkg::REF_W-1:0]    req_pos_ref,
   input  wire logic [vtdi_pkg::REF_W-1:0]    req_tex_ref,
   input  wire logic [vtdi_pkg::REF_W-1:0]    req_norm_ref,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [vtdi_pkg::VTX_W-1:0]         rsp_vertex_index,
   output logic                               rsp_is_new,
   output logic                               rsp_table_full,
   output logic [vtdi_pkg::REF_W-1:0]         rsp_new_pos,
   output logic signed [vtdi_pkg::ZREF_W-1:0] rsp_new_tex,
   output logic signed [vtdi_pkg::ZREF_W-1:0] rsp_new_norm
);
   import vtdi_pkg::*;

   logic [KEY_W-1:0]  key_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              hit_ff;
   logic [KEY_W-1:0]  rd_key;
   logic              full;
   logic              append;

   logic                     out_valid_ff;
   logic [VTX_W-1:0]         out_vtx_ff;
   logic                     out_new_ff;
   logic                     out_full_ff;
   logic [REF_W-1:0]         out_pos_ff;
   logic signed [ZREF_W-1:0] out_tex_ff;
   logic signed [ZREF_W-1:0] out_norm_ff;

   assign full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign append = cmd.emit && !hit_ff && !full;

   // Key store
   vtdi_ram #(
      .DATA_W (KEY_W),
      .DEPTH  (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (append),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_key)
   );

   // Status toward the controller
   always_comb begin
      st.clear_act = (req_action == ACT_CLEAR);
      st.empty     = (count_ff == '0);
      st.match     = (rd_key == key_ff);
      st.last      = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      st.slot_free = !out_valid_ff || !rsp_stall;
   end

   // Latch the request key, hold the scan index and hit flag
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= {req_pos_ref, req_tex_ref, req_norm_ref};
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.set_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // Entry count: clear on a clear action, advance on append
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load && (req_action == ACT_CLEAR)) begin
         count_ff <= '0;
      end else if (append) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Response valid: set on emit, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_vtx_ff  <= '0;
         out_new_ff  <= 1'b0;
         out_full_ff <= 1'b0;
         out_pos_ff  <= '0;
         out_tex_ff  <= '0;
         out_norm_ff <= '0;
         if (hit_ff) begin
            out_vtx_ff <= VTX_W'(idx_ff);
         end else if (full) begin
            out_full_ff <= 1'b1;
         end else begin
            out_vtx_ff  <= VTX_W'(count_ff);
            out_new_ff  <= 1'b1;
            out_pos_ff  <= key_ff[3*REF_W-1:2*REF_W] - REF_W'(1);
            out_tex_ff  <= {1'b0, key_ff[2*REF_W-1:REF_W]} - ZREF_W'(1);
            out_norm_ff <= {1'b0, key_ff[REF_W-1:0]} - ZREF_W'(1);
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_vertex_index = out_vtx_ff;
   assign rsp_is_new       = out_new_ff;
   assign rsp_table_full   = out_full_ff;
   assign rsp_new_pos      = out_pos_ff;
   assign rsp_new_tex      = out_tex_ff;
   assign rsp_new_norm     = out_norm_ff;

endmodule
`default_nettype wire

/* design/vertex_triple_dedup_indexer_unit.sv */
// Top level of the vertex triple dedup indexer: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Turns face-corner triples (position, texcoord, normal; one-based, 0 = absent)
// into index buffer entries. Each corner beat is looked up by a linear scan of
// the key store over the stored entries, one RAM read and one compare per
// entry; the scan runs through the single read port of the key RAM. A miss
// appends the triple and returns is_new with zero-based references (-1 for an
// absent texcoord or normal, all ones for an absent position); a miss on a full
// table returns table_full and stores nothing. A clear beat empties the table
// and produces no response. A new request beat is taken while a finished
// response still waits.
module vertex_triple_dedup_indexer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic [vtdi_pkg::REF_W-1:0]    req_pos_ref,
   input  wire logic [vtdi_pkg::REF_W-1:0]    req_tex_ref,
   input  wire logic [vtdi_pkg::REF_W-1:0]    req_norm_ref,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [vtdi_pkg::VTX_W-1:0]         rsp_vertex_index,
   output logic                               rsp_is_new,
   output logic                               rsp_table_full,
   output logic [vtdi_pkg::REF_W-1:0]         rsp_new_pos,
   output logic signed [vtdi_pkg::ZREF_W-1:0] rsp_new_tex,
   output logic signed [vtdi_pkg::ZREF_W-1:0] rsp_new_norm
);
   import vtdi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   // Sequencer
   vtdi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Key store and response path
   vtdi_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_action       (req_action),
      .req_pos_ref      (req_pos_ref),
      .req_tex_ref      (req_tex_ref),
      .req_norm_ref     (req_norm_ref),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .rsp_new_pos      (rsp_new_pos),
      .rsp_new_tex      (rsp_new_tex),
      .rsp_new_norm     (rsp_new_norm)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_vertex_triple_dedup_indexer_unit.sv */
// Self-checking testbench for the vertex triple dedup indexer unit.
`timescale 1ns / 1ps
module tb_vertex_triple_dedup_indexer_unit;
   import vtdi_pkg::*;

   localparam int unsigned QUIET_LIMIT = 20000;  // cycles with no beat before giving up
   localparam int unsigned HOLD_CYCLES = 300;    // long response hold-off
   localparam int unsigned TAIL_CYCLES = 50;
   localparam int unsigned PHASE_CORNERS = 125;

   // One expected response beat
   typedef struct packed {
      logic [VTX_W-1:0]         vertex_index;
      logic                     is_new;
      logic                     table_full;
      logic [REF_W-1:0]         new_pos;
      logic signed [ZREF_W-1:0] new_tex;
      logic signed [ZREF_W-1:0] new_norm;
   } corner_result_t;

   // One row of the directed stimulus table
   typedef struct packed {
      logic             act;
      logic [REF_W-1:0] pos;
      logic [REF_W-1:0] tex;
      logic [REF_W-1:0] norm;
      logic             typed;
      corner_result_t   want;
   } stim_row_t;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_action;
   logic [REF_W-1:0]          req_pos_ref;
   logic [REF_W-1:0]          req_tex_ref;
   logic [REF_W-1:0]          req_norm_ref;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [VTX_W-1:0]          rsp_vertex_index;
   logic                      rsp_is_new;
   logic                      rsp_table_full;
   logic [REF_W-1:0]          rsp_new_pos;
   logic signed [ZREF_W-1:0]  rsp_new_tex;
   logic signed [ZREF_W-1:0]  rsp_new_norm;

   // Testbench-side data that travels with each request beat
   logic                      row_typed;
   corner_result_t            row_result;

   // Predictor state: stored vertex keys and their count
   logic [KEY_W-1:0]          vertex_keys [TABLE_DEPTH];
   int unsigned               vertex_count;

   corner_result_t            pending_corners [$];
   stim_row_t                 directed_rows [$];
   int unsigned               mismatch_count;
   int unsigned               corners_sent;
   int unsigned               corners_checked;
   int unsigned               snd_idle_pct;
   int unsigned               rcv_stall_pct;
   int unsigned               hold_left;
   bit                        hold_start;

   vertex_triple_dedup_indexer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pos_ref      (req_pos_ref),
      .req_tex_ref      (req_tex_ref),
      .req_norm_ref     (req_norm_ref),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .rsp_new_pos      (rsp_new_pos),
      .rsp_new_tex      (rsp_new_tex),
      .rsp_new_norm     (rsp_new_norm)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Look up one corner in the predicted table; return 1 when a beat is due
   function automatic bit index_corner(input logic act, input logic [REF_W-1:0] pos,
                                       input logic [REF_W-1:0] tex,
                                       input logic [REF_W-1:0] norm,
                                       output corner_result_t res);
      logic [KEY_W-1:0] key;
      int unsigned      i;
      bit               found;
      res   = '0;
      found = 1'b0;
      if (act == ACT_CLEAR) begin
         vertex_count = 0;
         return 1'b0;
      end
      key = {pos, tex, norm};
      for (i = 0; i < vertex_count; i++) begin
         if (!found && vertex_keys[i] == key) begin
            found            = 1'b1;
            res.vertex_index = i[VTX_W-1:0];
         end
      end
      if (found)
         return 1'b1;
      if (vertex_count >= TABLE_DEPTH) begin
         res.table_full = 1'b1;
         return 1'b1;
      end
      // Append on a miss; an absent texcoord or normal comes out as -1
      vertex_keys[vertex_count] = key;
      res.vertex_index = vertex_count[VTX_W-1:0];
      res.is_new       = 1'b1;
      res.new_pos      = pos - 1'b1;
      res.new_tex      = {1'b0, tex} - 1'b1;
      res.new_norm     = {1'b0, norm} - 1'b1;
      vertex_count++;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("ERROR corner %0d %s: got %0d expected %0d", corners_checked, field, got, want);
      mismatch_count++;
   endtask

   // Predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      corner_result_t want;
      corner_result_t pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_corners.size() == 0) begin
               report_mismatch("unexpected beat, vertex_index", rsp_vertex_index, 0);
            end else begin
               want = pending_corners.pop_front();
               if (rsp_vertex_index !== want.vertex_index)
                  report_mismatch("vertex_index", rsp_vertex_index, want.vertex_index);
               if (rsp_is_new !== want.is_new)
                  report_mismatch("is_new", rsp_is_new, want.is_new);
               if (rsp_table_full !== want.table_full)
                  report_mismatch("table_full", rsp_table_full, want.table_full);
               if (rsp_new_pos !== want.new_pos)
                  report_mismatch("new_pos", rsp_new_pos, want.new_pos);
               if (rsp_new_tex !== want.new_tex)
                  report_mismatch("new_tex", rsp_new_tex, want.new_tex);
               if (rsp_new_norm !== want.new_norm)
                  report_mismatch("new_norm", rsp_new_norm, want.new_norm);
            end
            corners_checked++;
         end
         if (req_valid && !req_stall) begin
            if (index_corner(req_action, req_pos_ref, req_tex_ref, req_norm_ref, pred)) begin
               if (row_typed)
                  pred = row_result;
               pending_corners = {pending_corners, pred};
            end
         end
      end
   end

   // Watchdog: end the run after a long stretch with no beat on either side
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("TIMEOUT: no beat for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Receiver: random stall, or a long counted hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
         end
      end
   end

   // Offer one request beat after random gaps; return at the accepting edge
   task automatic send_beat(input logic act, input logic [REF_W-1:0] pos,
                            input logic [REF_W-1:0] tex, input logic [REF_W-1:0] norm,
                            input logic typed, input corner_result_t want);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pos_ref  <= pos;
      req_tex_ref  <= tex;
      req_norm_ref <= norm;
      row_typed    <= typed;
      row_result   <= want;
      if (act == ACT_INDEX)
         corners_sent++;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stop offering and hold until every expected beat has come back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_corners.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_row(input logic act, input logic [REF_W-1:0] pos,
                          input logic [REF_W-1:0] tex, input logic [REF_W-1:0] norm,
                          input logic typed, input corner_result_t want);
      stim_row_t row;
      row           = '{act, pos, tex, norm, typed, want};
      directed_rows = {directed_rows, row};
   endtask

   function automatic corner_result_t new_vertex(input int unsigned idx,
                                                 input logic [REF_W-1:0] p,
                                                 input logic signed [ZREF_W-1:0] t,
                                                 input logic signed [ZREF_W-1:0] n);
      return '{idx[VTX_W-1:0], 1'b1, 1'b0, p, t, n};
   endfunction

   // One mesh: a clear, then corners drawn from small pools so that repeats are common
   task automatic send_mesh(input int unsigned n_corners);
      logic [REF_W-1:0] pos_base, tex_base, norm_base, p, t, n;
      int unsigned      pos_span, tex_span, norm_span, roll;
      bit               tex_on, norm_on;
      pos_base  = REF_W'($urandom_range(1, 65535));
      tex_base  = REF_W'($urandom_range(1, 65535));
      norm_base = REF_W'($urandom_range(1, 65535));
      pos_span  = $urandom_range(1, 8);
      tex_span  = $urandom_range(1, 4);
      norm_span = $urandom_range(1, 4);
      tex_on    = ($urandom_range(0, 3) != 0);
      norm_on   = ($urandom_range(0, 3) != 0);
      send_beat(ACT_CLEAR, REF_W'($urandom), REF_W'($urandom), REF_W'($urandom), 1'b0, '0);
      repeat (n_corners) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            // noise: any triple at all
            send_beat(ACT_INDEX, REF_W'($urandom), REF_W'($urandom), REF_W'($urandom),
                      1'b0, '0);
         end else if (roll < 6) begin
            // broken mesh: clear in the middle
            send_beat(ACT_CLEAR, REF_W'($urandom), REF_W'($urandom), REF_W'($urandom),
                      1'b0, '0);
         end else begin
            p = REF_W'(pos_base + $urandom_range(0, pos_span - 1));
            t = tex_on ? REF_W'(tex_base + $urandom_range(0, tex_span - 1)) : '0;
            n = norm_on ? REF_W'(norm_base + $urandom_range(0, norm_span - 1)) : '0;
            send_beat(ACT_INDEX, p, t, n, 1'b0, '0);
         end
      end
   endtask

   initial begin
      corner_result_t   full_res;
      logic [REF_W-1:0] last_tex, last_norm, first_tex, first_norm;
      int unsigned      target, k, phase;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_INDEX;
      req_pos_ref    = '0;
      req_tex_ref    = '0;
      req_norm_ref   = '0;
      row_typed      = 1'b0;
      row_result     = '0;
      vertex_count   = 0;
      mismatch_count = 0;
      corners_sent   = 0;
      corners_checked = 0;
      snd_idle_pct   = 0;
      rcv_stall_pct  = 0;
      hold_start     = 1'b0;
      full_res       = '{'0, 1'b0, 1'b1, '0, '0, '0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, absent attributes, zero position, clears, near misses
      add_row(ACT_INDEX, 16'd1, 16'd1, 16'd1, 1'b1, new_vertex(0, 16'd0, 17'sd0, 17'sd0));
      add_row(ACT_INDEX, 16'd1, 16'd1, 16'd1, 1'b1, '0);
      add_row(ACT_INDEX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              new_vertex(1, 16'hFFFE, 17'sd65534, 17'sd65534));
      add_row(ACT_INDEX, 16'd1, 16'd0, 16'd0, 1'b1, new_vertex(2, 16'd0, -17'sd1, -17'sd1));
      add_row(ACT_INDEX, 16'd0, 16'd0, 16'd0, 1'b1,
              new_vertex(3, 16'hFFFF, -17'sd1, -17'sd1));
      add_row(ACT_INDEX, 16'd0, 16'd0, 16'd0, 1'b0, '0);
      add_row(ACT_INDEX, 16'd1, 16'd0, 16'd1, 1'b0, '0);
      add_row(ACT_INDEX, 16'd1, 16'd1, 16'd0, 1'b0, '0);
      add_row(ACT_INDEX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
      add_row(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
      add_row(ACT_INDEX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              new_vertex(0, 16'hFFFE, 17'sd65534, 17'sd65534));
      add_row(ACT_INDEX, 16'd1, 16'd1, 16'd1, 1'b0, '0);
      add_row(ACT_CLEAR, 16'd0, 16'd0, 16'd0, 1'b0, '0);
      add_row(ACT_CLEAR, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, '0);
      add_row(ACT_INDEX, 16'h8000, 16'd1, 16'h8000, 1'b1,
              new_vertex(0, 16'h7FFF, 17'sd0, 17'sd32767));
      add_row(ACT_INDEX, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0);
      add_row(ACT_INDEX, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0);
      add_row(ACT_INDEX, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0);
      add_row(ACT_INDEX, 16'h5555, 16'hAAAA, 16'h5554, 1'b0, '0);
      add_row(ACT_INDEX, 16'h5554, 16'hAAAA, 16'h5555, 1'b0, '0);
      add_row(ACT_INDEX, 16'h5555, 16'hAAAB, 16'h5555, 1'b0, '0);
      add_row(ACT_INDEX, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0, '0);
      foreach (directed_rows[k])
         send_beat(directed_rows[k].act, directed_rows[k].pos, directed_rows[k].tex,
                   directed_rows[k].norm, directed_rows[k].typed, directed_rows[k].want);
      drain();

      // Back-pressure: hold responses off while requests keep coming
      hold_start = 1'b1;
      send_mesh(40);
      drain();

      // Random meshes under each idling mix
      for (phase = 0; phase < 4; phase++) begin
         snd_idle_pct  = (phase == 1) ? 47 : (phase == 3) ? 19 : 0;
         rcv_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 19 : 0;
         target = corners_sent + PHASE_CORNERS;
         while (corners_sent < target)
            send_mesh($urandom_range(10, 60));
         drain();
      end

      // Fill the table completely, then probe the last and first entries and overflow
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      send_beat(ACT_CLEAR, '0, '0, '0, 1'b0, '0);
      first_tex  = REF_W'($urandom);
      first_norm = REF_W'($urandom);
      send_beat(ACT_INDEX, 16'd1, first_tex, first_norm, 1'b0, '0);
      for (k = 1; k < TABLE_DEPTH - 1; k++)
         send_beat(ACT_INDEX, REF_W'(k + 1), REF_W'($urandom), REF_W'($urandom), 1'b0, '0);
      last_tex  = REF_W'($urandom);
      last_norm = REF_W'($urandom);
      send_beat(ACT_INDEX, REF_W'(TABLE_DEPTH), last_tex, last_norm, 1'b0, '0);
      rcv_stall_pct = 47;
      send_beat(ACT_INDEX, REF_W'(TABLE_DEPTH), last_tex, last_norm, 1'b0, '0);
      send_beat(ACT_INDEX, 16'd1, first_tex, first_norm, 1'b0, '0);
      for (k = 0; k < 3; k++)
         send_beat(ACT_INDEX, REF_W'(5000 + k), REF_W'($urandom), REF_W'($urandom),
                   1'b1, full_res);
      send_beat(ACT_CLEAR, REF_W'($urandom), REF_W'($urandom), REF_W'($urandom), 1'b0, '0);
      send_beat(ACT_INDEX, 16'd1, 16'd1, 16'd1, 1'b1, new_vertex(0, 16'd0, 17'sd0, 17'sd0));
      drain();

      // Let any trailing clear settle, then report
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_corners.size() != 0)
         report_mismatch("beats never returned", 0, pending_corners.size());
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
